>>> hw/rtl/dns_query_fixed_answer_builder_defines.svh
// Assertion macros used by the responder top level.
`ifndef DNS_QUERY_FIXED_ANSWER_BUILDER_DEFINES_SVH
`define DNS_QUERY_FIXED_ANSWER_BUILDER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DNSFAB_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DNSFAB_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/dnsfab_pkg.sv
// Shared types, constants and functions of the DNS fixed-answer responder.
`default_nettype none
package dnsfab_pkg;

    localparam int MaxPacketWords = 64;
    localparam int MaxNameBytes   = 255;
    localparam int HdrLen         = 12;
    localparam int TailLen        = 20;
    localparam int Lanes          = 8;
    localparam int AddrW          = $clog2(MaxPacketWords);
    localparam int CountW         = AddrW + 1;
    localparam int IdxW           =
        $clog2(MaxPacketWords * 8 + HdrLen + MaxNameBytes + TailLen + 1);
    localparam int LaneW          = $clog2(Lanes);
    localparam int PaddrW         = 3;

    // Byte constants of the reply.
    localparam logic [7:0] FlagsHi = 8'h85;
    localparam logic [7:0] FlagsLo = 8'h80;
    localparam logic [7:0] QrBit   = 8'h80;
    localparam logic [7:0] Rcode   = 8'h05;
    localparam logic [7:0] PtrHi   = 8'hC0;
    localparam logic [7:0] PtrLo   = 8'h0C;
    localparam logic [7:0] RdLen   = 8'h04;

    // Header bytes 4 to 11 of a query with one question and nothing else.
    localparam logic [63:0] OneQuestion = 64'h0001_0000_0000_0000;

    // Register index of the answer address.
    localparam logic RegAnswerIpv4 = 1'b0;
    localparam logic [31:0] AnswerIpv4Reset = 32'hC0A8_0101;

    typedef logic [IdxW-1:0] idx_t;
    typedef logic [7:0]      byte_t;

    // Control shared by all byte lanes.
    typedef struct packed {
        logic echo;
        idx_t plen;
        idx_t qend;
        idx_t olen;
    } lane_ctl_t;

    // Byte of the fixed tail after the question name.
    function automatic byte_t tail_byte(input logic [4:0] sel, input logic [31:0] ip);
        byte_t b;
        begin
            b = 8'h00;
            case (sel)
                5'd1, 5'd3, 5'd7, 5'd9: b = 8'h01;
                5'd4:  b = PtrHi;
                5'd5:  b = PtrLo;
                5'd15: b = RdLen;
                5'd16: b = ip[31:24];
                5'd17: b = ip[23:16];
                5'd18: b = ip[15:8];
                5'd19: b = ip[7:0];
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/dnsfab_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module dnsfab_ram #(
    parameter int Width = 64,
    parameter int Depth = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hw/rtl/dnsfab_lane.sv
// One byte lane: terminator detection and reply byte selection.
`default_nettype none
module dnsfab_lane (
    input  wire logic                  [7:0] pkt_byte,
    input  wire dnsfab_pkg::idx_t            idx,
    input  wire dnsfab_pkg::lane_ctl_t       ctl,
    input  wire logic                 [31:0] ip,
    output dnsfab_pkg::byte_t                obyte,
    output logic                             zero
);

    dnsfab_pkg::idx_t toff;

    assign toff = idx - ctl.qend;

    // A zero byte past the header and inside the packet ends the name.
    assign zero = (pkt_byte == 8'h00) && (idx >= dnsfab_pkg::idx_t'(dnsfab_pkg::HdrLen))
                  && (idx < ctl.plen);

    // Reply byte: echoed packet, rewritten header, question copy or fixed tail.
    always_comb
    begin
        obyte = 8'h00;
        if (idx < ctl.olen)
        begin
            if (ctl.echo)
            begin
                if (idx == dnsfab_pkg::idx_t'(2))
                    obyte = pkt_byte | dnsfab_pkg::QrBit;
                else if (idx == dnsfab_pkg::idx_t'(3))
                    obyte = dnsfab_pkg::Rcode;
                else
                    obyte = pkt_byte;
            end
            else if (idx < dnsfab_pkg::idx_t'(dnsfab_pkg::HdrLen))
            begin
                if (idx == dnsfab_pkg::idx_t'(0) || idx == dnsfab_pkg::idx_t'(1))
                    obyte = pkt_byte;
                else if (idx == dnsfab_pkg::idx_t'(2))
                    obyte = dnsfab_pkg::FlagsHi;
                else if (idx == dnsfab_pkg::idx_t'(3))
                    obyte = dnsfab_pkg::FlagsLo;
                else if (idx == dnsfab_pkg::idx_t'(5) || idx == dnsfab_pkg::idx_t'(7))
                    obyte = 8'h01;
                else
                    obyte = 8'h00;
            end
            else if (idx < ctl.qend)
            begin
                obyte = pkt_byte;
            end
            else
            begin
                obyte = dnsfab_pkg::tail_byte(toff[4:0], ip);
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/dnsfab_merge.sv
// Merges the lane zero flags into the first terminator position of a word.
`default_nettype none
module dnsfab_merge (
    input  wire logic [dnsfab_pkg::Lanes-1:0] zero,
    output logic                              found,
    output logic [dnsfab_pkg::LaneW-1:0]      lane
);

    // Lowest lane wins, as it comes first on the wire.
    always_comb
    begin
        found = 1'b0;
        lane  = '0;
        for (int j = dnsfab_pkg::Lanes - 1; j >= 0; j--)
        begin
            if (zero[j])
            begin
                found = 1'b1;
                lane  = dnsfab_pkg::LaneW'(j);
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/dns_query_fixed_answer_builder.sv
// Top level of the DNS fixed-answer responder.
// Usage: a query payload enters as 8-byte words on in_data/in_bytes/in_last
// (valid/ready), first byte in bits 63:56; in_bytes matters on the last word.
// Words go into a 64-word packet RAM at one word a cycle. After the last word
// the header counts are checked; a good query then has its name terminator
// searched by eight byte lanes, word by word from word 1, and the reply is
// read back out of the RAM word by word (RAM read, then output register).
// A query with bad counts is echoed with rcode 5.
// Queries too short, too long, or with a bad name produce no reply.
// in_ready is high only while loading; the output register holds a word until
// out_ready takes it, and a stalled receiver stops the read-out there.
// Reset empties the buffer and sets answer_ipv4 to 192.168.1.1; the RAM
// itself is not cleared. answer_ipv4 is written over the APB port at 0.
`default_nettype none
`include "dns_query_fixed_answer_builder_defines.svh"
module dns_query_fixed_answer_builder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [63:0]                   in_data,
    input  wire logic [3:0]                    in_bytes,
    input  wire logic                          in_last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [63:0]                   out_data,
    output logic      [3:0]                    out_bytes,
    output logic                               out_last,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dnsfab_pkg::PaddrW-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    typedef enum logic [2:0] {
        ST_LOAD, ST_CHECK, ST_SCAN_RD, ST_SCAN_CHK, ST_EMIT_RD, ST_EMIT_FORM
    } state_t;

    state_t                          state_reg, state_next;
    logic [dnsfab_pkg::CountW-1:0]   wc_reg, wc_next;
    logic                            ovf_reg, ovf_next;
    logic [63:0]                     hdr_reg, hdr_next;
    logic [dnsfab_pkg::AddrW-1:0]    k_reg, k_next;
    dnsfab_pkg::lane_ctl_t           ctl_reg, ctl_next;
    logic [31:0]                     ip_reg, ip_next;
    logic                            ov_reg, ov_next;
    logic [63:0]                     od_reg, od_next;
    logic [3:0]                      ob_reg, ob_next;
    logic                            ol_reg, ol_next;

    logic                            in_acc, full, we;
    logic [3:0]                      nb;
    logic [63:0]                     data_m, rdata, lane_data;
    logic [dnsfab_pkg::Lanes-1:0]    zero;
    logic                            found;
    logic [dnsfab_pkg::LaneW-1:0]    first;
    dnsfab_pkg::idx_t                base, term, rem, plen_in;

    assign in_ready  = (state_reg == ST_LOAD);
    assign in_acc    = in_valid && in_ready;
    assign full      = (wc_reg == dnsfab_pkg::CountW'(dnsfab_pkg::MaxPacketWords));
    assign we        = in_acc && !full;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_bytes = ob_reg;
    assign out_last  = ol_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == dnsfab_pkg::RegAnswerIpv4) ? ip_reg : 32'h0;

    // Byte count of the incoming word and masking of bytes past it.
    always_comb
    begin
        if (!in_last || in_bytes > 4'd8)
            nb = 4'd8;
        else
            nb = in_bytes;
        for (int j = 0; j < 8; j++)
        begin
            data_m[63 - 8 * j -: 8] = (4'(j) < nb) ? in_data[63 - 8 * j -: 8] : 8'h00;
        end
    end

    assign plen_in = dnsfab_pkg::idx_t'({wc_reg[dnsfab_pkg::AddrW-1:0], 3'b000})
                     + dnsfab_pkg::idx_t'(nb);
    assign base    = dnsfab_pkg::idx_t'({k_reg, 3'b000});
    assign term    = base + dnsfab_pkg::idx_t'(first);
    assign rem     = ctl_reg.olen - base;

    // Packet store.
    dnsfab_ram #(
        .Width (64),
        .Depth (dnsfab_pkg::MaxPacketWords)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (wc_reg[dnsfab_pkg::AddrW-1:0]),
        .wdata (data_m),
        .raddr (k_reg),
        .rdata (rdata)
    );

    // Eight byte lanes working on the word read back.
    for (genvar g = 0; g < dnsfab_pkg::Lanes; g++)
    begin : g_lane
        dnsfab_lane u_lane (
            .pkt_byte (rdata[63 - 8 * g -: 8]),
            .idx      (base + dnsfab_pkg::idx_t'(g)),
            .ctl      (ctl_reg),
            .ip       (ip_reg),
            .obyte    (lane_data[63 - 8 * g -: 8]),
            .zero     (zero[g])
        );
    end

    // First terminator of the word.
    dnsfab_merge u_merge (
        .zero  (zero),
        .found (found),
        .lane  (first)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        wc_next    = wc_reg;
        ovf_next   = ovf_reg;
        hdr_next   = hdr_reg;
        k_next     = k_reg;
        ctl_next   = ctl_reg;
        ip_next    = ip_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        ob_next    = ob_reg;
        ol_next    = ol_reg;

        if (psel && penable && pwrite && paddr[2] == dnsfab_pkg::RegAnswerIpv4)
            ip_next = pwdata;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (full)
                        ovf_next = 1'b1;
                    else
                        wc_next = wc_reg + 1'b1;
                    if (wc_reg == '0)
                        hdr_next[63:32] = data_m[31:0];
                    if (wc_reg == dnsfab_pkg::CountW'(1))
                        hdr_next[31:0] = data_m[63:32];
                    if (in_last)
                    begin
                        wc_next  = '0;
                        ovf_next = 1'b0;
                        ctl_next.plen = plen_in;
                        if (!(ovf_reg || full)
                            && plen_in >= dnsfab_pkg::idx_t'(dnsfab_pkg::HdrLen))
                            state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (hdr_reg != dnsfab_pkg::OneQuestion)
                begin
                    ctl_next.echo = 1'b1;
                    ctl_next.olen = ctl_reg.plen;
                    ctl_next.qend = '0;
                    k_next        = '0;
                    state_next    = ST_EMIT_RD;
                end
                else
                begin
                    ctl_next.echo = 1'b0;
                    ctl_next.olen = '0;
                    ctl_next.qend = '0;
                    k_next        = dnsfab_pkg::AddrW'(1);
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (found)
                begin
                    if (term <= dnsfab_pkg::idx_t'(dnsfab_pkg::HdrLen
                                                   + dnsfab_pkg::MaxNameBytes - 1)
                        && term + dnsfab_pkg::idx_t'(5) <= ctl_reg.plen)
                    begin
                        ctl_next.qend = term + 1'b1;
                        ctl_next.olen = term + dnsfab_pkg::idx_t'(1 + dnsfab_pkg::TailLen);
                        k_next        = '0;
                        state_next    = ST_EMIT_RD;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
                else if (base + dnsfab_pkg::idx_t'(8) >= ctl_reg.plen)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_FORM;
            end
            ST_EMIT_FORM:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    od_next = lane_data;
                    ob_next = (rem >= dnsfab_pkg::idx_t'(8)) ? 4'd8 : rem[3:0];
                    ol_next = (base + dnsfab_pkg::idx_t'(8) >= ctl_reg.olen);
                    if (base + dnsfab_pkg::idx_t'(8) >= ctl_reg.olen)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            wc_reg    <= '0;
            ovf_reg   <= 1'b0;
            hdr_reg   <= '0;
            k_reg     <= '0;
            ctl_reg   <= '0;
            ip_reg    <= dnsfab_pkg::AnswerIpv4Reset;
            ov_reg    <= 1'b0;
            od_reg    <= '0;
            ob_reg    <= '0;
            ol_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wc_reg    <= wc_next;
            ovf_reg   <= ovf_next;
            hdr_reg   <= hdr_next;
            k_reg     <= k_next;
            ctl_reg   <= ctl_next;
            ip_reg    <= ip_next;
            ov_reg    <= ov_next;
            od_reg    <= od_next;
            ob_reg    <= ob_next;
            ol_reg    <= ol_next;
        end
    end

    // Overflow is only ever flagged with the store full.
    `DNSFAB_ASSERT_IMPL(a_ovf_full, clk, rst_n, ovf_reg, full, "overflow without full store")

    // Only the final reply word may be short.
    `DNSFAB_ASSERT_IMPL(a_short_last, clk, rst_n, ov_reg && !ol_reg, ob_reg == 4'd8,
        "short reply word before the end")

    // A last query word leaves the buffer empty.
    `DNSFAB_ASSERT_NEXT(a_last_clears, clk, rst_n, in_acc && in_last,
        wc_reg == '0 && !ovf_reg, "buffer not emptied after last word")

endmodule
`default_nettype wire
